// ===== rtl/isr_pkg.sv =====
// isr_pkg: shared constants for the integer square root block
// no dependencies; imported by the interfaces and the top level
package isr_pkg;

  // default width of the radicand field
  localparam int DEF_INPUT_BITS = 31;

  // fixed width of the root field; wider true roots keep only their low bits
  localparam int ROOT_BITS = 16;

endpackage

// ===== rtl/isr_ifs.sv =====
// isr_ifs: valid/ready channels carrying radicands in and roots out
// depends on isr_pkg for default widths
interface isr_operand_if
  import isr_pkg::*;
#(
  parameter int INPUT_BITS = DEF_INPUT_BITS
);
  logic                  valid;
  logic                  ready;
  logic [INPUT_BITS-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

interface isr_result_if
  import isr_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ROOT_BITS-1:0] root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

// ===== rtl/isr_cell.sv =====
// isr_cell: one restoring square root step, settles one root bit
// depends on nothing but its parameters; chained by integer_square_root
module isr_cell #(
  parameter int RW      = 32,
  parameter int BIT_POS = 30
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          valid_in,
  input  logic [RW-1:0] rem_in,
  input  logic [RW-1:0] res_in,
  output logic          valid_out,
  output logic [RW-1:0] rem_out,
  output logic [RW-1:0] res_out
);

  localparam logic [RW-1:0] STEP_BIT = RW'(1) << BIT_POS;

  logic [RW-1:0] trial;
  logic          fits;
  logic [RW-1:0] rem_next;
  logic [RW-1:0] res_next;

  always_comb begin
    trial = res_in + STEP_BIT;
    fits  = (rem_in >= trial);
    if (fits) begin
      rem_next = rem_in - trial;
      res_next = (res_in >> 1) + STEP_BIT;
    end else begin
      rem_next = rem_in;
      res_next = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      rem_out <= rem_next;
      res_out <= res_next;
    end
  end

endmodule

// ===== rtl/integer_square_root.sv =====
// integer_square_root: floor square root of an unsigned radicand
// depends on isr_pkg, isr_ifs (channels) and isr_cell (one step of the chain)
//
// Returns floor(sqrt(radicand)) for every radicand transfer, one root per
// radicand, in order. The root is built by a restoring method: a row of
// ceil(INPUT_BITS/2) identical cells, each settling one root bit from the
// most significant down, with a register after every cell. With the default
// 31-bit radicand that is 16 cells. While the row is not held, it shifts one
// place per cycle, so a new radicand can enter every cycle and the sustained
// rate is one item per cycle. The last cell doubles as the output register:
// while a finished root waits on result.ready the whole row holds and
// operand.ready is low. The root field is 16 bits; with INPUT_BITS above 32
// it carries the low 16 bits of the true root. There is no state between
// items and nothing to configure.
module integer_square_root
  import isr_pkg::*;
#(
  parameter int INPUT_BITS = DEF_INPUT_BITS
) (
  input  logic             clk,
  input  logic             rst,
  isr_operand_if.sink      operand,
  isr_result_if.source     result
);

  // number of root bits, one cell each
  localparam int STEPS = (INPUT_BITS + 1) / 2;
  // working width of remainder and partial root
  localparam int RW    = 2 * STEPS;

  logic          advance;
  logic          valid_chain [STEPS+1];
  logic [RW-1:0] rem_chain   [STEPS+1];
  logic [RW-1:0] res_chain   [STEPS+1];

  // the row moves unless a finished root sits unclaimed in the last cell
  assign advance       = !valid_chain[STEPS] || result.ready;
  assign operand.ready = advance;

  // head of the row: radicand zero-extended, partial root cleared
  assign valid_chain[0] = operand.valid;
  assign rem_chain[0]   = RW'(operand.radicand);
  assign res_chain[0]   = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    isr_cell #(
      .RW      (RW),
      .BIT_POS (2 * (STEPS - 1 - k))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .valid_in  (valid_chain[k]),
      .rem_in    (rem_chain[k]),
      .res_in    (res_chain[k]),
      .valid_out (valid_chain[k+1]),
      .rem_out   (rem_chain[k+1]),
      .res_out   (res_chain[k+1])
    );
  end

  // last cell holds the result transfer
  assign result.valid = valid_chain[STEPS];
  assign result.root  = ROOT_BITS'(res_chain[STEPS]);

endmodule
